FILE: rtl/core/round_robin_task_scheduler_assert.svh
// Assertion macros shared by the task scheduler RTL.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrts assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RRTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrts assertion failed");

`endif

FILE: rtl/core/rrts_pkg.sv
// Types and constants for the round-robin task scheduler.
`default_nettype none
package rrts_pkg;

    localparam int MAX_TASKS_DEF = 256;
    localparam int ID_W          = 8;
    localparam int CTX_W         = 32;
    localparam int CALL_W        = 32;

    localparam logic [CALL_W-1:0] SYS_WAITPID = 32'd7;
    localparam logic [CALL_W-1:0] SYS_EXIT    = 32'd1;

    localparam logic MODE_ADD = 1'b0;

    typedef enum logic [1:0] {
        TS_READY   = 2'd0,
        TS_RUNNING = 2'd1,
        TS_BLOCKED = 2'd2,
        TS_EXITED  = 2'd3
    } t_task_st;

    typedef enum logic [1:0] {
        RS_OK   = 2'd0,
        RS_FULL = 2'd1,
        RS_PASS = 2'd2,
        RS_NONE = 2'd3
    } t_res_st;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_EXEC   = 2'd1,
        ST_SEARCH = 2'd2,
        ST_PUSH   = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic search;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic is_short;
        logic hit;
        logic miss;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

FILE: rtl/core/rrts_ctrl.sv
// Controller state machine of the task scheduler.
`default_nettype none
`include "round_robin_task_scheduler_assert.svh"
module rrts_ctrl import rrts_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_stat.is_short ? ST_PUSH : ST_SEARCH;
            end
            ST_SEARCH: begin
                if (i_stat.hit || i_stat.miss) n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready      = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_EXEC:   o_cmd.exec   = 1'b1;
            ST_SEARCH: o_cmd.search = 1'b1;
            ST_PUSH:   o_cmd.push   = i_stat.out_free;
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    `RRTS_ASSERT_IMP(a_hit_miss_excl, i_clk, i_rst_n, i_stat.hit, !i_stat.miss)
    `RRTS_ASSERT_NXT(a_search_ends, i_clk, i_rst_n, (r_state == ST_SEARCH) && (i_stat.hit || i_stat.miss), r_state == ST_PUSH)
    `RRTS_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, (r_state == ST_IDLE) && i_valid, r_state == ST_EXEC)

endmodule
`default_nettype wire

FILE: rtl/core/rrts_dp.sv
// Datapath of the task scheduler: task table memories, search pipeline, result registers.
`default_nettype none
`include "round_robin_task_scheduler_assert.svh"
module rrts_dp import rrts_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  wire                i_mode,
    input  wire [CTX_W-1:0]    i_context_handle,
    input  wire [CALL_W-1:0]   i_syscall_number,
    input  wire [ID_W-1:0]     i_wait_pid,
    input  wire                i_hold,
    input  wire                i_ready,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic [ID_W-1:0]    o_task_id,
    output logic [CTX_W-1:0]   o_next_context
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = IDX_W + 1;

    // task table
    t_task_st          r_status_mem [MAX_TASKS];
    logic [ID_W-1:0]   r_wait_mem   [MAX_TASKS];
    logic [CTX_W-1:0]  r_ctx_mem    [MAX_TASKS];

    // latched request
    logic              r_mode;
    logic [CTX_W-1:0]  r_handle;
    logic [CALL_W-1:0] r_call;
    logic [ID_W-1:0]   r_wpid;
    logic              r_hold;

    // scheduler state
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_running;
    logic              r_running_valid;

    // search pipeline
    logic [IDX_W-1:0]  r_scan;
    logic [CNT_W-1:0]  r_issued;
    logic              r_p1_v;
    logic [IDX_W-1:0]  r_p1_idx;
    t_task_st          r_sa;
    logic [ID_W-1:0]   r_wa;
    logic [CTX_W-1:0]  r_ca;
    logic              r_p2_v;
    logic [IDX_W-1:0]  r_p2_idx;
    t_task_st          r_p2_sa;
    logic              r_p2_wok;
    logic [CTX_W-1:0]  r_p2_ctx;
    t_task_st          r_sb;

    // result and output registers
    t_res_st           r_res_status;
    logic [ID_W-1:0]   r_res_id;
    logic [CTX_W-1:0]  r_res_ctx;
    logic              r_out_valid;
    t_res_st           r_out_status;
    logic [ID_W-1:0]   r_out_id;
    logic [CTX_W-1:0]  r_out_ctx;

    logic              full;
    logic              do_add;
    logic              do_sched;
    logic              do_retire;
    logic              issuing;
    logic              hit;
    logic              miss;
    logic              runnable;
    logic              out_free;
    t_task_st          retire_st;
    logic [IDX_W-1:0]  start_idx;
    logic [IDX_W-1:0]  scan_next;
    logic              st_we;
    logic [IDX_W-1:0]  st_wa;
    t_task_st          st_wd;
    logic              wt_we;
    logic [IDX_W-1:0]  wt_wa;
    logic [ID_W-1:0]   wt_wd;
    logic              cx_we;
    logic [IDX_W-1:0]  cx_wa;

    assign full      = (r_count == CNT_W'(MAX_TASKS));
    assign do_add    = i_cmd.exec && (r_mode == MODE_ADD) && !full;
    assign do_sched  = (r_mode != MODE_ADD) && !r_hold && (r_count != '0);
    assign do_retire = i_cmd.exec && do_sched && r_running_valid;
    assign issuing   = i_cmd.search && (r_issued != r_count);
    assign out_free  = !r_out_valid || i_ready;

    assign runnable = (r_p2_sa == TS_READY) ||
                      ((r_p2_sa == TS_BLOCKED) && r_p2_wok && (r_sb == TS_EXITED));
    assign hit  = i_cmd.search && r_p2_v && runnable;
    assign miss = i_cmd.search && (r_issued == r_count) && !r_p1_v && !r_p2_v;

    // the running index is always below the count, so one compare wraps it
    assign start_idx = !r_running_valid ? '0 :
                       ((CNT_W'(r_running) + CNT_W'(1)) == r_count) ? '0 :
                       r_running + IDX_W'(1);
    assign scan_next = ((CNT_W'(r_scan) + CNT_W'(1)) == r_count) ? '0 : r_scan + IDX_W'(1);

    always_comb begin
        if (r_call == SYS_WAITPID) begin
            retire_st = TS_BLOCKED;
        end else if (r_call == SYS_EXIT) begin
            retire_st = TS_EXITED;
        end else begin
            retire_st = TS_READY;
        end
    end

    always_comb begin
        st_we = 1'b0;
        st_wa = r_running;
        st_wd = TS_READY;
        wt_we = 1'b0;
        wt_wa = r_running;
        wt_wd = r_wpid;
        cx_we = 1'b0;
        cx_wa = r_running;
        if (do_add) begin
            st_we = 1'b1;
            st_wa = r_count[IDX_W-1:0];
            st_wd = TS_READY;
            wt_we = 1'b1;
            wt_wa = r_count[IDX_W-1:0];
            wt_wd = '0;
            cx_we = 1'b1;
            cx_wa = r_count[IDX_W-1:0];
        end else if (do_retire) begin
            st_we = 1'b1;
            st_wd = retire_st;
            wt_we = (r_call == SYS_WAITPID);
            cx_we = 1'b1;
        end else if (hit) begin
            st_we = 1'b1;
            st_wa = r_p2_idx;
            st_wd = TS_RUNNING;
        end
    end

    // table memories: one write port each, status has a second read port
    always_ff @(posedge i_clk) begin
        if (st_we) r_status_mem[st_wa] <= st_wd;
        if (wt_we) r_wait_mem[wt_wa] <= wt_wd;
        if (cx_we) r_ctx_mem[cx_wa] <= r_handle;
        r_sa <= r_status_mem[r_scan];
        r_wa <= r_wait_mem[r_scan];
        r_ca <= r_ctx_mem[r_scan];
        r_sb <= r_status_mem[r_wa[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count         <= '0;
            r_running       <= '0;
            r_running_valid <= 1'b0;
            r_issued        <= '0;
            r_p1_v          <= 1'b0;
            r_p2_v          <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (do_add) r_count <= r_count + CNT_W'(1);
            if (i_cmd.exec) begin
                r_issued <= '0;
                r_p1_v   <= 1'b0;
                r_p2_v   <= 1'b0;
            end else if (i_cmd.search) begin
                r_p1_v <= issuing;
                r_p2_v <= r_p1_v;
                if (issuing) r_issued <= r_issued + CNT_W'(1);
            end
            if (hit) begin
                r_running       <= r_p2_idx;
                r_running_valid <= 1'b1;
            end else if (miss) begin
                r_running_valid <= 1'b0;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_mode;
            r_handle <= i_context_handle;
            r_call   <= i_syscall_number;
            r_wpid   <= i_wait_pid;
            r_hold   <= i_hold;
        end
        if (i_cmd.exec) begin
            r_scan <= start_idx;
        end else if (issuing) begin
            r_scan <= scan_next;
        end
        r_p1_idx <= r_scan;
        r_p2_idx <= r_p1_idx;
        r_p2_sa  <= r_sa;
        r_p2_ctx <= r_ca;
        // a waited id at or past the count never counts as exited
        r_p2_wok <= ((ID_W+1)'(r_wa) < (ID_W+1)'(r_count));
        if (i_cmd.exec) begin
            if (r_mode == MODE_ADD) begin
                r_res_status <= full ? RS_FULL : RS_OK;
                r_res_id     <= full ? '0 : ID_W'(r_count[IDX_W-1:0]);
                r_res_ctx    <= '0;
            end else begin
                r_res_status <= RS_PASS;
                r_res_id     <= ID_W'(r_running);
                r_res_ctx    <= r_handle;
            end
        end else if (hit) begin
            r_res_status <= RS_OK;
            r_res_id     <= ID_W'(r_p2_idx);
            r_res_ctx    <= r_p2_ctx;
        end else if (miss) begin
            r_res_status <= RS_NONE;
            r_res_id     <= '0;
            r_res_ctx    <= r_handle;
        end
        if (i_cmd.push) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_ctx    <= r_res_ctx;
        end
    end

    assign o_stat.is_short = !do_sched;
    assign o_stat.hit      = hit;
    assign o_stat.miss     = miss;
    assign o_stat.out_free = out_free;

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_task_id      = r_out_id;
    assign o_next_context = r_out_ctx;

    `RRTS_ASSERT_IMP(a_hit_in_range, i_clk, i_rst_n, hit, CNT_W'(r_p2_idx) < r_count)
    `RRTS_ASSERT_IMP(a_issue_bound, i_clk, i_rst_n, 1'b1, r_issued <= r_count)
    `RRTS_ASSERT_IMP(a_running_in_range, i_clk, i_rst_n, r_running_valid, CNT_W'(r_running) < r_count)

endmodule
`default_nettype wire

FILE: rtl/core/round_robin_task_scheduler.sv
// Flow: an add or a passed-through schedule request passes EXEC and PUSH after accept, then raises o_valid,
// and the next request is taken after PUSH has loaded the output register, when the output is free.
// A searching schedule request adds the SEARCH state, which reads one table entry per cycle
// through the status memory read ports until a runnable task is found or every task is scanned.
// One request is in work at a time; the next is taken once the result sits in the output register.
// Reset (i_rst_n low, synchronous) empties the table and clears the running task; memories keep data.
`default_nettype none
module round_robin_task_scheduler import rrts_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire                i_mode,
    input  wire [CTX_W-1:0]    i_context_handle,
    input  wire [CALL_W-1:0]   i_syscall_number,
    input  wire [ID_W-1:0]     i_wait_pid,
    input  wire                i_hold,
    output logic               o_valid,
    input  wire                i_ready,
    output logic [1:0]         o_status,
    output logic [ID_W-1:0]    o_task_id,
    output logic [CTX_W-1:0]   o_next_context
);

    t_cmd  cmd;
    t_stat stat;

    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rrts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_mode           (i_mode),
        .i_context_handle (i_context_handle),
        .i_syscall_number (i_syscall_number),
        .i_wait_pid       (i_wait_pid),
        .i_hold           (i_hold),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_task_id        (o_task_id),
        .o_next_context   (o_next_context)
    );

endmodule
`default_nettype wire

FILE: tb/rrts_dispatch_checker.sv
// Checker for the round-robin task scheduler: predicts every dispatch and compares results.
`timescale 1ns / 100ps
module rrts_dispatch_checker import rrts_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_req_valid,
    input  wire              i_req_ready,
    input  wire              i_mode,
    input  wire [CTX_W-1:0]  i_context_handle,
    input  wire [CALL_W-1:0] i_syscall_number,
    input  wire [ID_W-1:0]   i_wait_pid,
    input  wire              i_hold,
    input  wire              i_res_valid,
    input  wire              i_res_ready,
    input  wire [1:0]        i_status,
    input  wire [ID_W-1:0]   i_task_id,
    input  wire [CTX_W-1:0]  i_next_context,
    output int               o_pending,
    output int               o_fail_count
);

    typedef struct packed {
        t_res_st          status;
        logic [ID_W-1:0]  task_id;
        logic [CTX_W-1:0] next_context;
    } t_dispatch;

    t_task_st         task_st  [MAX_TASKS];
    logic [ID_W-1:0]  wait_on  [MAX_TASKS];
    logic [CTX_W-1:0] task_ctx [MAX_TASKS];
    int               task_cnt = 0;
    logic [ID_W-1:0]  run_idx  = '0;
    bit               run_live = 1'b0;
    t_dispatch        dispatch_q [$];
    int               fail_cnt = 0;

    // A blocked task may run again once the task it waits on has exited.
    function automatic bit can_run(int idx);
        int w;
        w = int'(wait_on[idx]);
        if (task_st[idx] == TS_READY)
            return 1'b1;
        return task_st[idx] == TS_BLOCKED && w < task_cnt && task_st[w] == TS_EXITED;
    endfunction

    function automatic t_dispatch next_dispatch(logic mode, logic [CTX_W-1:0] handle,
            logic [CALL_W-1:0] call, logic [ID_W-1:0] pid, logic hold);
        t_dispatch d;
        int first;
        int idx;
        if (mode == MODE_ADD) begin
            if (task_cnt >= MAX_TASKS) begin
                d = '{RS_FULL, '0, '0};
            end else begin
                task_st[task_cnt]  = TS_READY;
                wait_on[task_cnt]  = '0;
                task_ctx[task_cnt] = handle;
                d = '{RS_OK, ID_W'(task_cnt), '0};
                task_cnt++;
            end
            return d;
        end
        if (hold || task_cnt == 0)
            return '{RS_PASS, run_idx, handle};
        first = 0;
        // Retire the running task and save its handle before the search.
        if (run_live) begin
            if (call == SYS_WAITPID) begin
                task_st[run_idx] = TS_BLOCKED;
                wait_on[run_idx] = pid;
            end else if (call == SYS_EXIT) begin
                task_st[run_idx] = TS_EXITED;
            end else begin
                task_st[run_idx] = TS_READY;
            end
            task_ctx[run_idx] = handle;
            first = (int'(run_idx) + 1) % task_cnt;
        end
        for (int n = 0; n < task_cnt; n++) begin
            idx = (first + n) % task_cnt;
            if (can_run(idx)) begin
                task_st[idx] = TS_RUNNING;
                run_idx      = ID_W'(idx);
                run_live     = 1'b1;
                return '{RS_OK, ID_W'(idx), task_ctx[idx]};
            end
        end
        run_live = 1'b0;
        return '{RS_NONE, '0, handle};
    endfunction

    always @(posedge i_clk) begin : track
        t_dispatch want;
        if (!i_rst_n) begin
            task_cnt = 0;
            run_idx  = '0;
            run_live = 1'b0;
            dispatch_q.delete();
        end else begin
            // Retire the result first; a request never completes in its own accept cycle.
            if (i_res_valid && i_res_ready) begin
                if (dispatch_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected result: status %0d id %0d ctx %h",
                                 i_status, i_task_id, i_next_context);
                end else begin
                    want = dispatch_q.pop_front();
                    if (i_status !== want.status || i_task_id !== want.task_id ||
                            i_next_context !== want.next_context) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("mismatch: expected status %0d id %0d ctx %h, got status %0d id %0d ctx %h",
                                     want.status, want.task_id, want.next_context,
                                     i_status, i_task_id, i_next_context);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                dispatch_q.push_back(next_dispatch(i_mode, i_context_handle,
                                                   i_syscall_number, i_wait_pid, i_hold));
        end
        o_pending    <= dispatch_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

FILE: tb/tb_round_robin_task_scheduler.sv
// Testbench top for the round-robin task scheduler: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps
module tb_round_robin_task_scheduler;
    import rrts_pkg::*;

    localparam int   TABLE_SIZE   = MAX_TASKS_DEF;
    localparam int   TAIL_CYCLES  = 300;
    localparam int   RUN_LIMIT_NS = 8_000_000;
    localparam int   PHASE_ITEMS  = 350;
    localparam logic MODE_SCHED   = ~MODE_ADD;

    logic              i_clk;
    logic              i_rst_n          = 1'b0;
    logic              i_valid          = 1'b0;
    logic              i_mode           = MODE_ADD;
    logic [CTX_W-1:0]  i_context_handle = '0;
    logic [CALL_W-1:0] i_syscall_number = '0;
    logic [ID_W-1:0]   i_wait_pid       = '0;
    logic              i_hold           = 1'b0;
    logic              i_ready          = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [1:0]        o_status;
    logic [ID_W-1:0]   o_task_id;
    logic [CTX_W-1:0]  o_next_context;

    int pending_cnt;
    int fail_cnt;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int tasks_known = 0;

    int ph_idle  [5] = '{0, 82, 0, 38, 0};
    int ph_stall [5] = '{0, 0, 82, 38, 0};
    int ph_cap   [5] = '{16, 48, 96, 160, TABLE_SIZE};

    round_robin_task_scheduler #(.MAX_TASKS(TABLE_SIZE)) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_mode           (i_mode),
        .i_context_handle (i_context_handle),
        .i_syscall_number (i_syscall_number),
        .i_wait_pid       (i_wait_pid),
        .i_hold           (i_hold),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_task_id        (o_task_id),
        .o_next_context   (o_next_context)
    );

    rrts_dispatch_checker #(.MAX_TASKS(TABLE_SIZE)) dispatch_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_mode           (i_mode),
        .i_context_handle (i_context_handle),
        .i_syscall_number (i_syscall_number),
        .i_wait_pid       (i_wait_pid),
        .i_hold           (i_hold),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_status         (o_status),
        .i_task_id        (o_task_id),
        .i_next_context   (o_next_context),
        .o_pending        (pending_cnt),
        .o_fail_count     (fail_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Hold valid and payload until the request is taken.
    task automatic push_request(logic mode, logic [CTX_W-1:0] handle,
            logic [CALL_W-1:0] call, logic [ID_W-1:0] pid, logic hold);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_valid          <= 1'b1;
        i_mode           <= mode;
        i_context_handle <= handle;
        i_syscall_number <= call;
        i_wait_pid       <= pid;
        i_hold           <= hold;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (mode == MODE_ADD && tasks_known < TABLE_SIZE)
            tasks_known++;
    endtask

    task automatic add_task(logic [CTX_W-1:0] handle);
        push_request(MODE_ADD, handle, $urandom(), ID_W'($urandom()), 1'($urandom()));
    endtask

    task automatic run_sched(logic [CALL_W-1:0] call, logic [ID_W-1:0] pid, logic hold);
        push_request(MODE_SCHED, $urandom(), call, pid, hold);
    endtask

    // Drop valid and wait until every outstanding request has returned.
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
    endtask

    task automatic rand_request(int add_pct);
        int                pick;
        logic [CALL_W-1:0] call;
        logic [ID_W-1:0]   pid;
        if ($urandom_range(0, 99) < add_pct) begin
            add_task($urandom());
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                call = SYS_WAITPID;
            else if (pick < 33)
                call = SYS_EXIT;
            else if (pick < 45)
                call = CALL_W'($urandom_range(0, 15));
            else
                call = $urandom();
            // Mostly wait on a live id, sometimes on one past the table end.
            pick = $urandom_range(0, 99);
            if (pick < 70 && tasks_known > 0)
                pid = ID_W'($urandom_range(0, tasks_known - 1));
            else if (pick < 85 && tasks_known < 256)
                pid = ID_W'($urandom_range(tasks_known, 255));
            else
                pid = ID_W'($urandom());
            run_sched(call, pid, $urandom_range(0, 99) < 8);
        end
    endtask

    initial begin
        int add_pct;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: pass the handle through, with and without hold.
        push_request(MODE_SCHED, '1, '0, '0, 1'b0);
        push_request(MODE_SCHED, 32'h1234_5678, SYS_EXIT, '1, 1'b1);
        add_task('0);
        add_task('1);
        add_task(32'hA5A5_A5A5);
        run_sched('0, '0, 1'b0);
        run_sched(SYS_EXIT, '0, 1'b1);
        run_sched('1, '1, 1'b0);
        run_sched(SYS_WAITPID, 8'd2, 1'b0);
        run_sched(SYS_EXIT, '0, 1'b0);
        run_sched(SYS_EXIT, '0, 1'b0);
        // Wait on an id past the table: nothing left to run.
        run_sched(SYS_WAITPID, '1, 1'b0);
        run_sched('0, '0, 1'b0);
        run_sched(SYS_WAITPID, '0, 1'b1);
        add_task($urandom());
        run_sched(32'd6, '0, 1'b0);
        run_sched(SYS_WAITPID, 8'd3, 1'b0);
        add_task($urandom());
        run_sched(32'd8, '0, 1'b0);
        run_sched(32'h8000_0007, '1, 1'b0);
        run_sched(SYS_EXIT, '0, 1'b0);
        add_task($urandom());
        run_sched(32'd0, '0, 1'b0);
        run_sched(SYS_WAITPID, 8'd6, 1'b0);
        add_task($urandom());

        for (int ph = 0; ph < 5; ph++) begin
            drain;
            idle_pct  = ph_idle[ph];
            stall_pct = ph_stall[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (tasks_known < ph_cap[ph])
                    add_pct = (ph_cap[ph] >= TABLE_SIZE) ? 45 : 30;
                else
                    add_pct = (ph_cap[ph] >= TABLE_SIZE) ? 10 : 0;
                rand_request(add_pct);
            end
        end

        drain;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && pending_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
